FILE: rtl/sdst_pkg.sv
// shared constants for the segment-to-segment distance block
`timescale 1ns / 1ps
`default_nettype none
package sdst_pkg;
  // width of the distance result port
  localparam int OUT_BITS = 17;
  // address bits of the queue between front and back
  localparam int MID_AW = 2;
  // address bits of the result queue
  localparam int OUT_AW = 1;
  // quotient bits of the projection divider beyond the coordinate width
  localparam int QUO_EXTRA = 3;
endpackage
`default_nettype wire

FILE: rtl/sdst_fifo.sv
// small first-in first-out queue with registered pointers
`timescale 1ns / 1ps
`default_nettype none
module sdst_fifo #(
  parameter int W  = 8,
  parameter int AW = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic         pop,
  input  logic [W-1:0] wdata,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int DEPTH = 1 << AW;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  // status
  assign full    = (count == (AW + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sdst_front.sv
// front end: takes requests, flags zero-length segments, feeds the queue
`timescale 1ns / 1ps
`default_nettype none
module sdst_front #(
  parameter int CB = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [8*CB-1:0]   coords,
  output logic              q_push,
  input  logic              q_full,
  output logic [8*CB+1:0]   q_data
);
  logic              f_valid;
  logic [8*CB+1:0]   f_data;
  logic              adv;
  logic [CB-1:0]     ax, ay, bx, by, cx, cy, dx, dy;
  logic              degen_ab;
  logic              degen_cd;

  assign {ax, ay, bx, by, cx, cy, dx, dy} = coords;

  // zero-length segments have no projection
  assign degen_ab = (ax == bx) && (ay == by);
  assign degen_cd = (cx == dx) && (cy == dy);

  assign adv    = ~f_valid | ~q_full;
  assign full   = ~adv;
  assign q_push = f_valid;
  assign q_data = f_data;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && push) begin
      f_data <= {coords, degen_ab, degen_cd};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sdst_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module sdst_div #(
  parameter int NUMW = 52,
  parameter int DENW = 34,
  parameter int QB   = 19,
  parameter int SW   = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [QB-1:0]   quo,
  output logic            rem_nz,
  output logic [SW-1:0]   side_out
);
  localparam int CW = ((NUMW > DENW + QB) ? NUMW : DENW + QB) + 1;

  logic [NUMW-1:0] rr [QB];
  logic [DENW-1:0] dd [QB];
  logic [QB-1:0]   qq [QB];
  logic [SW-1:0]   ss [QB];
  logic            vv [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NUMW-1:0] r_in;
    logic [DENW-1:0] d_in;
    logic [QB-1:0]   q_in;
    logic [SW-1:0]   s_in;
    logic            v_in;
    logic [CW-1:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign s_in = side_in;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rr[k-1];
      assign d_in = dd[k-1];
      assign q_in = qq[k-1];
      assign s_in = ss[k-1];
      assign v_in = vv[k-1];
    end

    // compare against the shifted divisor
    assign trial = CW'(d_in) << (QB - 1 - k);
    assign take  = CW'(r_in) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k] <= 1'b0;
      end else if (en) begin
        vv[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[k] <= take ? (r_in - NUMW'(trial)) : r_in;
        dd[k] <= d_in;
        qq[k] <= q_in | (take ? (QB'(1) << (QB - 1 - k)) : '0);
        ss[k] <= s_in;
      end
    end
  end

  assign out_valid = vv[QB-1];
  assign quo       = qq[QB-1];
  assign rem_nz    = |rr[QB-1];
  assign side_out  = ss[QB-1];
endmodule
`default_nettype wire

FILE: rtl/sdst_proj.sv
// point-to-segment projection: min of base and squared distance to the foot if it lies in the box
`timescale 1ns / 1ps
`default_nettype none
module sdst_proj #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CB-1:0] px,
  input  logic signed [CB-1:0] py,
  input  logic signed [CB-1:0] sx,
  input  logic signed [CB-1:0] sy,
  input  logic signed [CB-1:0] ex,
  input  logic signed [CB-1:0] ey,
  input  logic                 degen,
  input  logic [2*CB+1:0]      base,
  output logic                 out_valid,
  output logic [2*CB+1:0]      best
);
  import sdst_pkg::*;

  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int DENW = 2 * CB + 2;
  localparam int LB   = DW + 1;
  localparam int LOW  = DW + LB + 1;
  localparam int HIW  = DW + NW - LB;
  localparam int XW   = DW + NW;
  localparam int QB   = CB + QUO_EXTRA;
  localparam int QW   = QB + 2;
  localparam int SQW  = 2 * CB + 2;
  localparam int SUMW = 2 * (QW + 1) + 1;
  localparam int SW   = 6 * CB + 2 + SQW;

  // stage 1: normal, cross terms, squared lengths, box
  logic signed [DW-1:0] ox_c, oy_c, sxp, eyp, syp, exq;
  logic signed [CB-1:0] xlo_c, xhi_c, ylo_c, yhi_c;
  logic                 v1, v2, v3, v4;
  logic signed [DW-1:0] ox1, oy1;
  logic signed [PW-1:0] m1, m2, dxx, dyy;
  logic signed [CB-1:0] px1, py1, xlo1, xhi1, ylo1, yhi1;
  logic                 dg1;
  logic [SQW-1:0]       base1;

  assign ox_c  = DW'(ey) - DW'(sy);
  assign oy_c  = DW'(sx) - DW'(ex);
  assign sxp   = DW'(sx) - DW'(px);
  assign eyp   = DW'(ey) - DW'(py);
  assign syp   = DW'(sy) - DW'(py);
  assign exq   = DW'(ex) - DW'(px);
  assign xlo_c = (sx < ex) ? sx : ex;
  assign xhi_c = (sx > ex) ? sx : ex;
  assign ylo_c = (sy < ey) ? sy : ey;
  assign yhi_c = (sy > ey) ? sy : ey;

  always_ff @(posedge clk) begin
    if (en) begin
      ox1   <= ox_c;
      oy1   <= oy_c;
      m1    <= sxp * eyp;
      m2    <= syp * exq;
      dxx   <= ox_c * ox_c;
      dyy   <= oy_c * oy_c;
      px1   <= px;
      py1   <= py;
      xlo1  <= xlo_c;
      xhi1  <= xhi_c;
      ylo1  <= ylo_c;
      yhi1  <= yhi_c;
      dg1   <= degen;
      base1 <= base;
    end
  end

  // stage 2: cross product and squared length
  logic signed [NW-1:0] num2;
  logic [DENW-1:0]      den2;
  logic signed [DW-1:0] ox2, oy2;
  logic signed [CB-1:0] px2, py2, xlo2, xhi2, ylo2, yhi2;
  logic                 dg2;
  logic [SQW-1:0]       base2;

  always_ff @(posedge clk) begin
    if (en) begin
      num2  <= NW'(m1) - NW'(m2);
      den2  <= DENW'($unsigned(dxx)) + DENW'($unsigned(dyy));
      ox2   <= ox1;
      oy2   <= oy1;
      px2   <= px1;
      py2   <= py1;
      xlo2  <= xlo1;
      xhi2  <= xhi1;
      ylo2  <= ylo1;
      yhi2  <= yhi1;
      dg2   <= dg1;
      base2 <= base1;
    end
  end

  // stage 3: normal times cross product as two partial products
  logic [LB-1:0]          nl;
  logic signed [NW-LB-1:0] nh;
  logic signed [LOW-1:0]  lox, loy;
  logic signed [HIW-1:0]  hix, hiy;
  logic [DENW-1:0]        den3;
  logic signed [CB-1:0]   px3, py3, xlo3, xhi3, ylo3, yhi3;
  logic                   dg3;
  logic [SQW-1:0]         base3;

  assign nl = num2[LB-1:0];
  assign nh = $signed(num2[NW-1:LB]);

  always_ff @(posedge clk) begin
    if (en) begin
      lox   <= ox2 * $signed({1'b0, nl});
      loy   <= oy2 * $signed({1'b0, nl});
      hix   <= ox2 * nh;
      hiy   <= oy2 * nh;
      den3  <= den2;
      px3   <= px2;
      py3   <= py2;
      xlo3  <= xlo2;
      xhi3  <= xhi2;
      ylo3  <= ylo2;
      yhi3  <= yhi2;
      dg3   <= dg2;
      base3 <= base2;
    end
  end

  // stage 4: combine partial products, split sign and magnitude
  logic signed [XW-1:0] xx, xy;
  logic [XW-1:0]        magx, magy;
  logic                 sgx, sgy;
  logic [DENW-1:0]      den4;
  logic signed [CB-1:0] px4, py4, xlo4, xhi4, ylo4, yhi4;
  logic                 dg4;
  logic [SQW-1:0]       base4;

  assign xx = (XW'(hix) <<< LB) + XW'(lox);
  assign xy = (XW'(hiy) <<< LB) + XW'(loy);

  always_ff @(posedge clk) begin
    if (en) begin
      sgx   <= xx[XW-1];
      sgy   <= xy[XW-1];
      magx  <= xx[XW-1] ? $unsigned(-xx) : $unsigned(xx);
      magy  <= xy[XW-1] ? $unsigned(-xy) : $unsigned(xy);
      den4  <= den3;
      px4   <= px3;
      py4   <= py3;
      xlo4  <= xlo3;
      xhi4  <= xhi3;
      ylo4  <= ylo3;
      yhi4  <= yhi3;
      dg4   <= dg3;
      base4 <= base3;
    end
  end

  // valid bits through the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // dividers, x carries the side data
  logic [SW-1:0]        side_in, side_out;
  logic                 vd, vdy;
  logic [QB-1:0]        qmx, qmy;
  logic                 nzx, nzy;
  logic                 sgy_d;
  logic signed [CB-1:0] pxd, pyd, xlod, xhid, ylod, yhid;
  logic                 dgd, sgx_d;
  logic [SQW-1:0]       based;

  assign side_in = {px4, py4, xlo4, xhi4, ylo4, yhi4, dg4, sgx, base4};
  assign {pxd, pyd, xlod, xhid, ylod, yhid, dgd, sgx_d, based} = side_out;

  sdst_div #(.NUMW(XW), .DENW(DENW), .QB(QB), .SW(SW)) u_divx (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .num      (magx),
    .den      (den4),
    .side_in  (side_in),
    .out_valid(vd),
    .quo      (qmx),
    .rem_nz   (nzx),
    .side_out (side_out)
  );

  sdst_div #(.NUMW(XW), .DENW(DENW), .QB(QB), .SW(1)) u_divy (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .num      (magy),
    .den      (den4),
    .side_in  (sgy),
    .out_valid(vdy),
    .quo      (qmy),
    .rem_nz   (nzy),
    .side_out (sgy_d)
  );

  // stage 5: foot point, truncated toward zero
  logic signed [QW-1:0] tx, ty, fx_c, fy_c;
  logic signed [QW-1:0] fx5, fy5;
  logic signed [CB-1:0] px5, py5, xlo5, xhi5, ylo5, yhi5;
  logic                 dg5, v5;
  logic [SQW-1:0]       base5;

  assign tx = sgx_d ? (QW'(pxd) - $signed({2'b00, qmx})) : (QW'(pxd) + $signed({2'b00, qmx}));
  assign ty = sgy_d ? (QW'(pyd) - $signed({2'b00, qmy})) : (QW'(pyd) + $signed({2'b00, qmy}));

  always_comb begin
    fx_c = tx;
    fy_c = ty;
    if (!sgx_d && nzx && tx < 0) begin
      fx_c = tx + QW'(1);
    end else if (sgx_d && nzx && tx > 0) begin
      fx_c = tx - QW'(1);
    end
    if (!sgy_d && nzy && ty < 0) begin
      fy_c = ty + QW'(1);
    end else if (sgy_d && nzy && ty > 0) begin
      fy_c = ty - QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx5   <= fx_c;
      fy5   <= fy_c;
      px5   <= pxd;
      py5   <= pyd;
      xlo5  <= xlod;
      xhi5  <= xhid;
      ylo5  <= ylod;
      yhi5  <= yhid;
      dg5   <= dgd;
      base5 <= based;
    end
  end

  // stage 6: box check and offsets to the point
  logic                   in_box;
  logic                   ok6, v6;
  logic signed [QW:0]     dqx, dqy;
  logic [SQW-1:0]         base6;

  assign in_box = (fx5 >= QW'(xlo5)) && (fx5 <= QW'(xhi5)) &&
                  (fy5 >= QW'(ylo5)) && (fy5 <= QW'(yhi5));

  always_ff @(posedge clk) begin
    if (en) begin
      ok6   <= in_box & ~dg5;
      dqx   <= (QW + 1)'(fx5) - (QW + 1)'(px5);
      dqy   <= (QW + 1)'(fy5) - (QW + 1)'(py5);
      base6 <= base5;
    end
  end

  // stage 7: squared distance to the foot, keep the smaller
  logic signed [2*QW+1:0] sqx, sqy;
  logic [SUMW-1:0]        sum;
  logic                   v7;
  logic [SQW-1:0]         best7;

  assign sqx = dqx * dqx;
  assign sqy = dqy * dqy;
  assign sum = SUMW'($unsigned(sqx)) + SUMW'($unsigned(sqy));

  always_ff @(posedge clk) begin
    if (en) begin
      best7 <= (ok6 && sum < SUMW'(base6)) ? SQW'(sum) : base6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v5 <= vd & vdy;
      v6 <= v5;
      v7 <= v6;
    end
  end

  assign out_valid = v7;
  assign best      = best7;
endmodule
`default_nettype wire

FILE: rtl/sdst_back.sv
// back end: endpoint distances, four projections, minimum and square root
`timescale 1ns / 1ps
`default_nettype none
module sdst_back #(
  parameter int CB = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [8*CB+1:0] in_data,
  output logic            in_pop,
  output logic            res_valid,
  output logic [CB:0]     res,
  input  logic            hold
);
  localparam int DW  = CB + 1;
  localparam int PW  = 2 * DW;
  localparam int SQW = 2 * CB + 2;
  localparam int RW  = CB + 1;
  localparam int RMW = RW + 2;

  logic adv;

  // whole pipeline moves unless a finished result is blocked
  assign adv    = ~(res_valid & hold);
  assign in_pop = adv & in_valid;

  // entry stage
  logic            s0_valid;
  logic [8*CB+1:0] s0_data;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_data <= in_data;
    end
  end

  logic signed [CB-1:0] ax0, ay0, bx0, by0, cx0, cy0, dx0, dy0;
  logic                 dab0, dcd0;
  assign {ax0, ay0, bx0, by0, cx0, cy0, dx0, dy0, dab0, dcd0} = s0_data;

  // endpoint pair offsets squared
  logic signed [CB-1:0] epx [4];
  logic signed [CB-1:0] epy [4];
  logic signed [CB-1:0] eqx [4];
  logic signed [CB-1:0] eqy [4];
  logic signed [DW-1:0] edx [4];
  logic signed [DW-1:0] edy [4];
  logic signed [PW-1:0] esq [8];
  logic                 s1_valid;
  logic [8*CB+1:0]      s1_data;

  assign epx = '{ax0, ax0, bx0, bx0};
  assign epy = '{ay0, ay0, by0, by0};
  assign eqx = '{cx0, dx0, cx0, dx0};
  assign eqy = '{cy0, dy0, cy0, dy0};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      edx[k] = DW'(epx[k]) - DW'(eqx[k]);
      edy[k] = DW'(epy[k]) - DW'(eqy[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        esq[2*k]   <= edx[k] * edx[k];
        esq[2*k+1] <= edy[k] * edy[k];
      end
      s1_data <= s0_data;
    end
  end

  // nearest endpoint pair
  logic [SQW-1:0]  esum [4];
  logic [SQW-1:0]  emin01, emin23;
  logic [SQW-1:0]  s2_base;
  logic            s2_valid;
  logic [8*CB+1:0] s2_data;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      esum[k] = SQW'($unsigned(esq[2*k])) + SQW'($unsigned(esq[2*k+1]));
    end
  end

  assign emin01 = (esum[0] < esum[1]) ? esum[0] : esum[1];
  assign emin23 = (esum[2] < esum[3]) ? esum[2] : esum[3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_base <= (emin01 < emin23) ? emin01 : emin23;
      s2_data <= s1_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  logic signed [CB-1:0] ax2, ay2, bx2, by2, cx2, cy2, dx2, dy2;
  logic                 dab2, dcd2;
  assign {ax2, ay2, bx2, by2, cx2, cy2, dx2, dy2, dab2, dcd2} = s2_data;

  // each endpoint against the other segment
  logic signed [CB-1:0] ppx [4];
  logic signed [CB-1:0] ppy [4];
  logic signed [CB-1:0] psx [4];
  logic signed [CB-1:0] psy [4];
  logic signed [CB-1:0] pex [4];
  logic signed [CB-1:0] pey [4];
  logic                 pdg [4];
  logic                 pv [4];
  logic [SQW-1:0]       pbest [4];

  assign ppx = '{cx2, dx2, ax2, bx2};
  assign ppy = '{cy2, dy2, ay2, by2};
  assign psx = '{ax2, ax2, cx2, cx2};
  assign psy = '{ay2, ay2, cy2, cy2};
  assign pex = '{bx2, bx2, dx2, dx2};
  assign pey = '{by2, by2, dy2, dy2};
  assign pdg = '{dab2, dab2, dcd2, dcd2};

  for (genvar k = 0; k < 4; k++) begin : g_proj
    sdst_proj #(.CB(CB)) u_proj (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (s2_valid),
      .px       (ppx[k]),
      .py       (ppy[k]),
      .sx       (psx[k]),
      .sy       (psy[k]),
      .ex       (pex[k]),
      .ey       (pey[k]),
      .degen    (pdg[k]),
      .base     (s2_base),
      .out_valid(pv[k]),
      .best     (pbest[k])
    );
  end

  // smallest squared distance
  logic [SQW-1:0] pmin01, pmin23;
  logic [SQW-1:0] m_val;
  logic           m_valid;

  assign pmin01 = (pbest[0] < pbest[1]) ? pbest[0] : pbest[1];
  assign pmin23 = (pbest[2] < pbest[3]) ? pbest[2] : pbest[3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m_val <= (pmin01 < pmin23) ? pmin01 : pmin23;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= pv[0] & pv[1] & pv[2] & pv[3];
    end
  end

  // square root, one result bit per stage
  logic [SQW-1:0] sn [RW];
  logic [RMW-1:0] sr [RW];
  logic [RW-1:0]  st [RW];
  logic           sv [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int J = RW - 1 - k;
    logic [SQW-1:0] n_in;
    logic [RMW-1:0] r_in;
    logic [RW-1:0]  t_in;
    logic           v_in;
    logic [RMW-1:0] r_sh;
    logic [RMW-1:0] trial;
    logic           take;

    if (k == 0) begin : g_first
      assign n_in = m_val;
      assign r_in = '0;
      assign t_in = '0;
      assign v_in = m_valid;
    end else begin : g_next
      assign n_in = sn[k-1];
      assign r_in = sr[k-1];
      assign t_in = st[k-1];
      assign v_in = sv[k-1];
    end

    assign r_sh  = {r_in[RMW-3:0], n_in[2*J +: 2]};
    assign trial = {t_in, 2'b01};
    assign take  = r_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (adv) begin
        sv[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sn[k] <= n_in;
        sr[k] <= take ? (r_sh - trial) : r_sh;
        st[k] <= {t_in[RW-2:0], take};
      end
    end
  end

  assign res_valid = sv[RW-1];
  assign res       = st[RW-1];
endmodule
`default_nettype wire

FILE: rtl/segment_to_segment_distance_top.sv
// top level of the segment-to-segment distance block
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  request  | push / full          | first_ax .. second_by, signed fixed point
//  result   | pop / empty          | min_distance, unsigned, floored
//
// one request per cycle sustained while full stays low; the depth of the
// back pipeline is set by the bit-per-stage projection dividers and the
// bit-per-stage square root.
// rst clears all valid bits and queue pointers.
// a blocked result holds the back pipeline; the queue between front and back
// then fills and full rises.
`timescale 1ns / 1ps
`default_nettype none
module segment_to_segment_distance_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic signed [COORD_BITS-1:0]       first_ax,
  input  logic signed [COORD_BITS-1:0]       first_ay,
  input  logic signed [COORD_BITS-1:0]       first_bx,
  input  logic signed [COORD_BITS-1:0]       first_by,
  input  logic signed [COORD_BITS-1:0]       second_ax,
  input  logic signed [COORD_BITS-1:0]       second_ay,
  input  logic signed [COORD_BITS-1:0]       second_bx,
  input  logic signed [COORD_BITS-1:0]       second_by,
  output logic                               empty,
  input  logic                               pop,
  output logic [sdst_pkg::OUT_BITS-1:0]      min_distance
);
  import sdst_pkg::*;

  localparam int IW = 8 * COORD_BITS + 2;

  logic          q_push;
  logic          q_full;
  logic [IW-1:0] q_wdata;
  logic [IW-1:0] q_rdata;
  logic          q_empty;
  logic          q_pop;
  logic          res_valid;
  logic [COORD_BITS:0] res;
  logic          o_full;

  // front: accept and classify
  sdst_front #(.CB(COORD_BITS)) u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .coords({first_ax, first_ay, first_bx, first_by,
             second_ax, second_ay, second_bx, second_by}),
    .q_push(q_push),
    .q_full(q_full),
    .q_data(q_wdata)
  );

  // queue between front and back
  sdst_fifo #(.W(IW), .AW(MID_AW)) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .pop  (q_pop),
    .wdata(q_wdata),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  // back: distance pipeline
  sdst_back #(.CB(COORD_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (~q_empty),
    .in_data  (q_rdata),
    .in_pop   (q_pop),
    .res_valid(res_valid),
    .res      (res),
    .hold     (o_full)
  );

  // result queue
  sdst_fifo #(.W(OUT_BITS), .AW(OUT_AW)) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_valid),
    .pop  (pop),
    .wdata(OUT_BITS'(res)),
    .rdata(min_distance),
    .full (o_full),
    .empty(empty)
  );
endmodule
`default_nettype wire
